@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
// Each macro expects clk to be visible where it is used; ASSERT_CLK also needs rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clock edge, suspended while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check on every rising clock edge, also during reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/lrupr_pkg.sv @@
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared types and constants of the LRU page replacement block.
// ----------------------------------------------------------------------------
package lrupr_pkg;

    // Fixed field widths
    localparam int PAGE_W = 7;
    localparam int CFG_W  = 7;
    localparam int CNT_W  = 32;

    // Frame limit after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // Broadcast from the control logic to every cell
    typedef struct packed {
        logic              update;   // word accepted this cycle
        logic              room;     // a miss may take a free frame
        logic [PAGE_W-1:0] page;     // referenced page, already reduced
    } lrupr_ctrl_t;

    // Handed from one cell to the next, most recent end first
    typedef struct packed {
        logic              seen;     // page matched in a more recent cell
        logic [PAGE_W-1:0] ev_page;  // page of the least recent cell, else 0
        logic [PAGE_W-1:0] page;     // page held by the cell above
    } lrupr_link_t;

endpackage

@@ rtl/core/lrupr_cell.sv @@
// ----------------------------------------------------------------------------
// lrupr_cell
// One position of the recency stack: holds a page, compares it with the
// reference and shifts in the page from the position above when told.
// ----------------------------------------------------------------------------
module lrupr_cell
    import lrupr_pkg::*;
#(
    parameter int OCC_W = 7,
    parameter int POS   = 0
)
(
    input  logic              clk,
    input  lrupr_ctrl_t       ctrl,
    input  logic [OCC_W-1:0]  occ,
    input  lrupr_link_t       link_in,
    output lrupr_link_t       link_out
);

    localparam logic [OCC_W-1:0] IDX      = OCC_W'(POS);
    localparam logic [OCC_W-1:0] IDX_NEXT = OCC_W'(POS + 1);

    logic [PAGE_W-1:0] page_reg;
    logic [PAGE_W-1:0] page_next;
    logic              occupied;
    logic              at_occ;
    logic              at_last;
    logic              match;
    logic              load;

    // Position decode against the fill level
    assign occupied = (IDX < occ);
    assign at_occ   = (IDX == occ);
    assign at_last  = (IDX_NEXT == occ);

    assign match = occupied && (page_reg == ctrl.page);

    // Shift while no more recent cell has matched; the first free cell
    // takes part only on a miss with room left
    assign load = ctrl.update && !link_in.seen && (occupied || (at_occ && ctrl.room));

    always_comb
    begin
        page_next = load ? link_in.page : page_reg;
    end

    // Hand on to the next cell
    always_comb
    begin
        link_out.seen    = link_in.seen | match;
        link_out.ev_page = link_in.ev_page | (at_last ? page_reg : '0);
        link_out.page    = page_reg;
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

endmodule

@@ rtl/core/lru_page_replacement_top.sv @@
// ----------------------------------------------------------------------------
// lru_page_replacement_top
// LRU page replacement: recency stack as a row of cells, hit and eviction
// reporting and a saturating hit count per run.
// ----------------------------------------------------------------------------
// The block takes one page reference per clock while in_stall is low and
// returns one result word per reference from an output register. A new word
// is taken whenever that register is empty or being drained, so the rate
// is one item per cycle while out_stall is low. The recency stack is a row of
// MAX_FRAMES cells; the match flag and the evicted page ripple through all
// of them in the same cycle, so the row length sets the clock period. After
// reset the block is ready at once: there is no clearing pass, and entries
// past the fill level are never looked at. A reference flagged final_ref is
// reported normally and then empties the stack and clears the hit count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lru_page_replacement_top
    import lrupr_pkg::*;
#(
    parameter int PAGE_COUNT = 128,
    parameter int MAX_FRAMES = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              cfg_wr_en,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    // reference input
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [PAGE_W-1:0] page_number,
    input  logic              final_ref,
    // result output
    output logic              out_valid,
    input  logic              out_stall,
    output logic              hit,
    output logic              evicted_valid,
    output logic [PAGE_W-1:0] evicted_page,
    output logic [CNT_W-1:0]  hit_total
);

    localparam int OCC_W = $clog2(MAX_FRAMES + 1);
    localparam int PAGE_VALUES = 2 ** PAGE_W;

    logic [CFG_W-1:0]  frames_in_use_reg;
    logic [OCC_W-1:0]  occ_reg;
    logic [OCC_W-1:0]  occ_next;
    logic [CNT_W-1:0]  hit_cnt_reg;
    logic [CNT_W-1:0]  hit_cnt_next;
    logic [CNT_W-1:0]  hit_cnt_upd;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              hit_reg;
    logic              evicted_valid_reg;
    logic [PAGE_W-1:0] evicted_page_reg;
    logic [CNT_W-1:0]  hit_total_reg;

    logic              accept;
    logic [OCC_W-1:0]  lim;
    logic              room;
    logic              hit_now;
    logic              ev_valid_now;
    logic [PAGE_W-1:0] page_red;
    logic [PAGE_W-1:0] page_mod_tab [PAGE_VALUES];
    lrupr_ctrl_t       ctrl;
    lrupr_link_t       links [MAX_FRAMES+1];

    // Handshake: output register frees the input side
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // Page number reduced modulo the page count, by constant table
    for (genvar g = 0; g < PAGE_VALUES; g++) begin : g_mod
        assign page_mod_tab[g] = PAGE_W'(g % PAGE_COUNT);
    end
    assign page_red = page_mod_tab[page_number];

    // Effective frame limit, clamped to 1..MAX_FRAMES
    always_comb
    begin
        if (16'(frames_in_use_reg) > 16'(MAX_FRAMES))
            lim = OCC_W'(MAX_FRAMES);
        else if (frames_in_use_reg == '0)
            lim = OCC_W'(1);
        else
            lim = OCC_W'(frames_in_use_reg);
    end
    assign room = (occ_reg < lim);

    // Cell row
    assign ctrl.update = accept;
    assign ctrl.room   = room;
    assign ctrl.page   = page_red;

    assign links[0].seen    = 1'b0;
    assign links[0].ev_page = '0;
    assign links[0].page    = page_red;

    for (genvar c = 0; c < MAX_FRAMES; c++) begin : g_cell
        lrupr_cell #(
            .OCC_W (OCC_W),
            .POS   (c)
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .occ      (occ_reg),
            .link_in  (links[c]),
            .link_out (links[c+1])
        );
    end

    assign hit_now      = links[MAX_FRAMES].seen;
    assign ev_valid_now = !hit_now && !room;

    // Fill level and hit count
    always_comb
    begin
        hit_cnt_upd = hit_cnt_reg;
        if (hit_now && (hit_cnt_reg != '1))
            hit_cnt_upd = hit_cnt_reg + CNT_W'(1);

        occ_next     = occ_reg;
        hit_cnt_next = hit_cnt_reg;
        if (accept)
        begin
            if (final_ref)
            begin
                occ_next     = '0;
                hit_cnt_next = '0;
            end
            else
            begin
                hit_cnt_next = hit_cnt_upd;
                if (!hit_now && room)
                    occ_next = occ_reg + OCC_W'(1);
            end
        end
    end

    assign out_valid_next = accept || (out_valid_reg && out_stall);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_in_use_reg <= CFG_RESET;
            occ_reg           <= '0;
            hit_cnt_reg       <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                frames_in_use_reg <= cfg_wr_data;
            occ_reg       <= occ_next;
            hit_cnt_reg   <= hit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result word register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg           <= hit_now;
            evicted_valid_reg <= ev_valid_now;
            evicted_page_reg  <= ev_valid_now ? links[MAX_FRAMES].ev_page : '0;
            hit_total_reg     <= hit_cnt_upd;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_page  = evicted_page_reg;
    assign hit_total     = hit_total_reg;

    // Checks
    `ASSERT_CLK(a_occ_bound, occ_reg <= OCC_W'(MAX_FRAMES), "fill level above frame count")
    `ASSERT_CLK(a_hit_xor_evict, out_valid_reg |-> !(hit_reg && evicted_valid_reg), "hit and eviction together")
    `ASSERT_CLK(a_final_clears, (accept && final_ref) |=> (occ_reg == '0 && hit_cnt_reg == '0), "final reference did not clear state")
    `ASSERT_CLK(a_cnt_monotonic, (accept && !final_ref) |=> (hit_cnt_reg >= $past(hit_cnt_reg)), "hit count went down")

endmodule

@@ sim/lru_page_replacement_top_test.sv @@
// ----------------------------------------------------------------------------
// lru_page_replacement_top_test
// Self-checking bench for the LRU page replacement block. A short table of
// directed references and frame limits comes first, then random runs over a
// drifting working set. Each result word is checked against a table entry
// or an in-bench recency-stack predictor, with random idling on both sides.
// ----------------------------------------------------------------------------
module lru_page_replacement_top_test
    import lrupr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAMES_MAX   = 64;
    localparam int RANDOM_RUNS  = 12;
    localparam int REFS_PER_RUN = 45;
    localparam int LONG_HOLD    = 60;   // cycles the sink refuses words once
    localparam int HOLD_AT      = 300;  // result count at which that happens

    typedef struct packed {
        logic              hit;
        logic              ev_valid;
        logic [PAGE_W-1:0] ev_page;
        logic [CNT_W-1:0]  total;
    } page_result_t;

    typedef enum logic { ROW_REF, ROW_CFG } row_kind_t;
    typedef enum logic { FROM_MODEL, FROM_TABLE } want_src_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [PAGE_W-1:0] value;   // page, or frame limit on a config row
        logic              fin;
        want_src_t         src;
        page_result_t      want;
    } plan_row_t;

    localparam page_result_t NONE = '0;

    // Directed references: fill, hit, evict, final, odd limits, limit lowered
    localparam int PLAN_ROWS = 26;
    localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
        '{ROW_CFG, 7'd2,   1'b0, FROM_MODEL, NONE},
        '{ROW_REF, 7'd0,   1'b0, FROM_TABLE, '{1'b0, 1'b0, 7'd0,   32'd0}},
        '{ROW_REF, 7'd127, 1'b0, FROM_TABLE, '{1'b0, 1'b0, 7'd0,   32'd0}},
        '{ROW_REF, 7'd0,   1'b0, FROM_TABLE, '{1'b1, 1'b0, 7'd0,   32'd1}},
        '{ROW_REF, 7'd5,   1'b0, FROM_TABLE, '{1'b0, 1'b1, 7'd127, 32'd1}},
        '{ROW_REF, 7'd0,   1'b0, FROM_MODEL, NONE},
        '{ROW_REF, 7'd127, 1'b1, FROM_MODEL, NONE},
        '{ROW_REF, 7'd127, 1'b0, FROM_TABLE, '{1'b0, 1'b0, 7'd0,   32'd0}},
        // limit of zero behaves as one frame
        '{ROW_CFG, 7'd0,   1'b0, FROM_MODEL, NONE},
        '{ROW_REF, 7'd127, 1'b0, FROM_MODEL, NONE},
        '{ROW_REF, 7'd42,  1'b0, FROM_MODEL, NONE},
        '{ROW_REF, 7'd42,  1'b1, FROM_MODEL, NONE},
        // limit above the frame count behaves as the full stack
        '{ROW_CFG, 7'd127, 1'b0, FROM_MODEL, NONE},
        '{ROW_REF, 7'd1,   1'b0, FROM_MODEL, NONE},
        '{ROW_REF, 7'd2,   1'b0, FROM_MODEL, NONE},
        '{ROW_REF, 7'd3,   1'b0, FROM_MODEL, NONE},
        '{ROW_REF, 7'd4,   1'b0, FROM_MODEL, NONE},
        '{ROW_REF, 7'd1,   1'b0, FROM_MODEL, NONE},
        // limit lowered below occupancy mid-run
        '{ROW_CFG, 7'd2,   1'b0, FROM_MODEL, NONE},
        '{ROW_REF, 7'd9,   1'b0, FROM_MODEL, NONE},
        '{ROW_REF, 7'd3,   1'b0, FROM_MODEL, NONE},
        '{ROW_REF, 7'd10,  1'b1, FROM_MODEL, NONE},
        '{ROW_CFG, 7'd64,  1'b0, FROM_MODEL, NONE},
        '{ROW_REF, 7'd85,  1'b0, FROM_MODEL, NONE},
        '{ROW_REF, 7'd42,  1'b0, FROM_MODEL, NONE},
        '{ROW_REF, 7'd85,  1'b1, FROM_MODEL, NONE}
    };

    logic              clk;
    logic              rst_n         = 1'b0;
    logic              cfg_wr_en     = 1'b0;
    logic [CFG_W-1:0]  cfg_wr_data   = '0;
    logic              in_valid      = 1'b0;
    logic              in_stall;
    logic [PAGE_W-1:0] page_number   = '0;
    logic              final_ref     = 1'b0;
    logic              out_valid;
    logic              out_stall     = 1'b0;
    logic              hit;
    logic              evicted_valid;
    logic [PAGE_W-1:0] evicted_page;
    logic [CNT_W-1:0]  hit_total;

    // Predictor state
    logic [PAGE_W-1:0] page_order [FRAMES_MAX];
    int                pages_held = 0;
    logic [CNT_W-1:0]  run_hits   = '0;
    logic [CFG_W-1:0]  frame_limit = CFG_RESET;

    page_result_t awaited_results [$];
    int           error_count = 0;
    bit           calm = 1'b0;      // no random idling on either side while set

    lru_page_replacement_top #(
        .PAGE_COUNT (128),
        .MAX_FRAMES (FRAMES_MAX)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .page_number   (page_number),
        .final_ref     (final_ref),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .hit_total     (hit_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Frame limit as the block applies it
    function automatic int usable_frames(input logic [CFG_W-1:0] limit);
        if (limit == 0)
            return 1;
        if (limit > FRAMES_MAX)
            return FRAMES_MAX;
        return int'(limit);
    endfunction

    // One reference through the recency stack; returns the word it yields
    function automatic page_result_t touch_page(input logic [PAGE_W-1:0] page,
                                                input logic fin);
        page_result_t r;
        int           slot;
        int           top;
        r    = '0;
        slot = -1;
        for (int k = 0; k < pages_held; k++)
            if (slot < 0 && page_order[k] == page)
                slot = k;
        if (slot >= 0)
        begin
            r.hit = 1'b1;
            top   = slot;
            if (run_hits != '1)
                run_hits++;
        end
        else if (pages_held < usable_frames(frame_limit))
        begin
            top = pages_held;
            pages_held++;
        end
        else
        begin
            // stack full (or over a lowered limit): drop the bottom entry
            r.ev_valid = 1'b1;
            r.ev_page  = page_order[pages_held-1];
            top        = pages_held - 1;
        end
        for (int k = top; k > 0; k--)
            page_order[k] = page_order[k-1];
        page_order[0] = page;
        r.total = run_hits;
        if (fin)
        begin
            pages_held = 0;
            run_hits   = '0;
        end
        return r;
    endfunction

    // Offer one reference, wait for it to be taken, log what should come back
    task automatic send_ref(input logic [PAGE_W-1:0] page, input logic fin,
                            input want_src_t src, input page_result_t table_want);
        int           gap;
        page_result_t model_want;
        gap = calm ? 0 : int'($urandom_range(0, 3));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        page_number <= page;
        final_ref   <= fin;
        do
            @(posedge clk);
        while (in_stall);
        model_want = touch_page(page, fin);
        awaited_results.push_back(src == FROM_TABLE ? table_want : model_want);
    endtask

    // Frame limit is only changed once the block has drained
    task automatic write_frame_limit(input logic [CFG_W-1:0] value);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        frame_limit = value;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Result sink: random hold-offs, one long one, and the word check
    initial
    begin : result_sink
        int           hold;
        int           results_seen;
        bit           long_hold_done;
        page_result_t want;
        results_seen   = 0;
        long_hold_done = 1'b0;
        wait (rst_n);
        forever
        begin
            hold = calm ? 0 : int'($urandom_range(0, 3));
            if (!long_hold_done && results_seen == HOLD_AT)
            begin
                hold           = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
            results_seen++;
            if (awaited_results.size() == 0)
            begin
                $error("result word with nothing expected");
                error_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("hit",           32'(want.hit),      32'(hit));
                check_field("evicted_valid", 32'(want.ev_valid), 32'(evicted_valid));
                check_field("evicted_page",  32'(want.ev_page),  32'(evicted_page));
                check_field("hit_total",     want.total,         hit_total);
            end
        end
    end

    // Stimulus: reset, directed table, then random runs
    initial
    begin : stimulus
        logic [CFG_W-1:0]  limit;
        logic [PAGE_W-1:0] base;
        logic [PAGE_W-1:0] page;
        logic              fin;
        int                span;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_PLAN[i])
        begin
            if (DIRECTED_PLAN[i].kind == ROW_CFG)
                write_frame_limit(DIRECTED_PLAN[i].value);
            else
                send_ref(DIRECTED_PLAN[i].value, DIRECTED_PLAN[i].fin,
                         DIRECTED_PLAN[i].src, DIRECTED_PLAN[i].want);
        end

        // Random runs; finals are sparse so limits often change mid-run
        for (int run = 0; run < RANDOM_RUNS; run++)
        begin
            case (run)
                0:       limit = 7'd1;
                1:       limit = 7'd64;
                2:       limit = 7'd127;
                3:       limit = 7'd0;
                default: limit = ($urandom_range(0, 3) == 0) ?
                                 CFG_W'($urandom_range(0, 127)) :
                                 CFG_W'($urandom_range(1, 8));
            endcase
            write_frame_limit(limit);
            calm = (run % 4 == 1);
            base = PAGE_W'($urandom_range(0, 127));
            span = usable_frames(limit) + 3;
            for (int n = 0; n < REFS_PER_RUN; n++)
            begin
                // mostly a working set a little larger than the stack
                if ($urandom_range(0, 9) < 7)
                    page = PAGE_W'(base + $urandom_range(0, span));
                else
                    page = PAGE_W'($urandom_range(0, 127));
                fin = ($urandom_range(0, 39) == 0);
                send_ref(page, fin, FROM_MODEL, NONE);
            end
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("lru_page_replacement_top_test: done, clean");
        else
            $display("lru_page_replacement_top_test: done, errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("lru_page_replacement_top_test: done, errors");
        $finish;
    end

endmodule
